### sv/periodic_measure_offload_sequencer_top_macros.svh
// assertion macros for the measure/offload sequencer
`ifndef PERIODIC_MEASURE_OFFLOAD_SEQUENCER_TOP_MACROS_SVH
`define PERIODIC_MEASURE_OFFLOAD_SEQUENCER_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PMOS_CHECK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("pmos check failed");

// property whose consequent must hold in the cycle after the antecedent
`define PMOS_CHECK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("pmos next-cycle check failed");

`endif

### sv/pmos_pkg.sv
package pmos_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFLOAD_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROFILE_TIME   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LIMIT   = 3'd4;

   // register reset values
   localparam logic [7:0]  REPLY_TIMEOUT_RESET = 8'd5;
   localparam logic [15:0] SAMPLE_LIMIT_RESET  = 16'd1;

   // command codes
   localparam logic [1:0] CMD_NONE        = 2'd0;
   localparam logic [1:0] CMD_GO_MEASURE  = 2'd1;
   localparam logic [1:0] CMD_GO_STANDBY  = 2'd2;
   localparam logic [1:0] CMD_OFFLOAD     = 2'd3;

   // outcome codes
   localparam logic [2:0] OUT_RUNNING         = 3'd0;
   localparam logic [2:0] OUT_DONE            = 3'd1;
   localparam logic [2:0] OUT_BAD_RATE        = 3'd2;
   localparam logic [2:0] OUT_BAD_DURATION    = 3'd3;
   localparam logic [2:0] OUT_PERIOD_TOO_LONG = 3'd4;
   localparam logic [2:0] OUT_NO_MEASURE_ACK  = 3'd5;
   localparam logic [2:0] OUT_NO_STANDBY_ACK  = 3'd6;
   localparam logic [2:0] OUT_OFFLOAD_FAILED  = 3'd7;

   // time constants
   localparam logic [31:0] MS_PER_S          = 32'd1000;
   localparam logic [31:0] MEASURE_MARGIN_MS = 32'd2000;

   // sequencer phases
   typedef enum logic [6:0] {
      PH_ENTRY           = 7'b0000001,
      PH_GO_MEASURE      = 7'b0000010,
      PH_CONFIRM_MEASURE = 7'b0000100,
      PH_MEASURE_WAIT    = 7'b0001000,
      PH_GO_STANDBY      = 7'b0010000,
      PH_CONFIRM_STANDBY = 7'b0100000,
      PH_OFFLOAD         = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [15:0] offload_period_s;
      logic [15:0] sample_rate_s;
      logic [31:0] profile_time_s;
      logic [7:0]  reply_timeout_s;
      logic [15:0] samples_per_period_limit;
   } cfg_type;

   typedef struct packed {
      logic        restart;
      logic        cancel;
      logic        measure_ack;
      logic        standby_ack;
      logic        offload_done;
      logic        offload_ok;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] command_period_s;
      logic        finished;
      logic [2:0]  outcome;
      logic        resume_pending;
      logic [15:0] period_count;
   } rsp_item_type;

endpackage

### sv/pmos_csr.sv
module pmos_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pmos_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output pmos_pkg::cfg_type              cfg
);
   import pmos_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    csr_write;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_OFFLOAD_PERIOD: cfg_in.offload_period_s = csr_data[15:0];
            CSR_SAMPLE_RATE:    cfg_in.sample_rate_s = csr_data[15:0];
            CSR_PROFILE_TIME:   cfg_in.profile_time_s = csr_data;
            CSR_REPLY_TIMEOUT:  cfg_in.reply_timeout_s = csr_data[7:0];
            CSR_SAMPLE_LIMIT:   cfg_in.samples_per_period_limit = csr_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offload_period_s         <= '0;
         cfg_ff.sample_rate_s            <= '0;
         cfg_ff.profile_time_s           <= '0;
         cfg_ff.reply_timeout_s          <= REPLY_TIMEOUT_RESET;
         cfg_ff.samples_per_period_limit <= SAMPLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/pmos_core.sv
module pmos_core (
   input  logic                   clock,
   input  logic                   reset,
   input  pmos_pkg::cfg_type      cfg,
   input  logic                   step_en,
   input  pmos_pkg::req_item_type item,
   output pmos_pkg::rsp_item_type rsp
);
   import pmos_pkg::*;

   // sequencer state
   phase_type   phase_ff,       phase_in;
   logic        retried_ff,     retried_in;
   logic [31:0] remaining_ff,   remaining_in;
   logic [15:0] cur_period_ff,  cur_period_in;
   logic [31:0] period_end_ff,  period_end_in;
   logic [31:0] reply_end_ff,   reply_end_in;
   logic        resume_ff,      resume_in;
   logic        measure_ack_ff, measure_ack_in;
   logic        standby_ack_ff, standby_ack_in;
   logic [15:0] periods_ff,     periods_in;

   phase_type   phase_cur;
   logic [31:0] reply_ms;
   logic [31:0] period_ms;
   logic [31:0] longest_s;
   logic [31:0] limit_s;
   logic [15:0] next_period_s;
   logic [31:0] period_take_s;

   // deadline reached when the signed difference is not negative
   function automatic logic deadline_hit(input logic [31:0] now, input logic [31:0] deadline);
      logic [31:0] diff;
      diff = now - deadline;
      return ~diff[31];
   endfunction

   // period length for the next go-measure, tail folded in, saturated
   function automatic logic [15:0] period_pick(input logic [15:0] offload_s,
                                               input logic [15:0] rate_s,
                                               input logic [31:0] remain_s);
      logic [16:0] p;
      logic [31:0] p32;
      logic [31:0] sel;
      logic        take_all;
      p = {1'b0, offload_s};
      if (p <= {1'b0, rate_s}) begin
         p = {1'b0, rate_s} + 17'd1;
      end
      p32 = {15'b0, p};
      take_all = (offload_s == 16'd0) || (remain_s <= p32) ||
                 ((remain_s - p32) <= {16'b0, rate_s});
      sel = take_all ? remain_s : p32;
      return (sel > 32'd65535) ? 16'hFFFF : sel[15:0];
   endfunction

   // arithmetic shared by the phases
   assign reply_ms      = {24'b0, cfg.reply_timeout_s} * MS_PER_S;
   assign period_ms     = {16'b0, cur_period_ff} * MS_PER_S;
   assign longest_s     = (cfg.offload_period_s == 16'd0) ? cfg.profile_time_s
                                                          : {16'b0, cfg.offload_period_s};
   assign limit_s       = {16'b0, cfg.samples_per_period_limit} * {16'b0, cfg.sample_rate_s};
   assign next_period_s = period_pick(cfg.offload_period_s, cfg.sample_rate_s, remaining_ff);
   assign period_take_s = (remaining_ff < {16'b0, cur_period_ff}) ? remaining_ff
                                                                 : {16'b0, cur_period_ff};

   // one poll: next state and result
   always_comb begin
      phase_cur      = item.restart ? PH_ENTRY : phase_ff;
      phase_in       = phase_cur;
      retried_in     = retried_ff;
      remaining_in   = remaining_ff;
      cur_period_in  = cur_period_ff;
      period_end_in  = period_end_ff;
      reply_end_in   = reply_end_ff;
      resume_in      = resume_ff;
      measure_ack_in = measure_ack_ff | item.measure_ack;
      standby_ack_in = standby_ack_ff | item.standby_ack;
      periods_in     = periods_ff;

      rsp.command          = CMD_NONE;
      rsp.command_period_s = '0;
      rsp.finished         = 1'b0;
      rsp.outcome          = OUT_RUNNING;

      if (item.cancel) begin
         // cancel: no more measuring, route to a final standby and offload
         resume_in    = 1'b0;
         remaining_in = '0;
         if (phase_cur != PH_OFFLOAD && phase_cur != PH_GO_STANDBY &&
             phase_cur != PH_CONFIRM_STANDBY) begin
            retried_in = 1'b0;
            phase_in   = PH_GO_STANDBY;
         end
      end else begin
         unique case (phase_cur)
            PH_GO_MEASURE: begin
               cur_period_in        = next_period_s;
               measure_ack_in       = 1'b0;
               standby_ack_in       = 1'b0;
               rsp.command          = CMD_GO_MEASURE;
               rsp.command_period_s = next_period_s;
               reply_end_in         = item.now_ms + reply_ms;
               phase_in             = PH_CONFIRM_MEASURE;
            end
            PH_CONFIRM_MEASURE: begin
               if (measure_ack_in) begin
                  retried_in    = 1'b0;
                  period_end_in = item.now_ms + period_ms + MEASURE_MARGIN_MS;
                  phase_in      = PH_MEASURE_WAIT;
               end else if (deadline_hit(item.now_ms, reply_end_ff)) begin
                  if (!retried_ff) begin
                     retried_in = 1'b1;
                     phase_in   = PH_GO_MEASURE;
                  end else begin
                     retried_in   = 1'b0;
                     rsp.finished = 1'b1;
                     rsp.outcome  = OUT_NO_MEASURE_ACK;
                  end
               end
            end
            PH_MEASURE_WAIT: begin
               if (deadline_hit(item.now_ms, period_end_ff)) begin
                  remaining_in = remaining_ff - period_take_s;
                  resume_in    = (remaining_ff != period_take_s);
                  phase_in     = PH_GO_STANDBY;
               end
            end
            PH_GO_STANDBY: begin
               standby_ack_in = 1'b0;
               rsp.command    = CMD_GO_STANDBY;
               reply_end_in   = item.now_ms + reply_ms;
               phase_in       = PH_CONFIRM_STANDBY;
            end
            PH_CONFIRM_STANDBY: begin
               if (standby_ack_in) begin
                  retried_in  = 1'b0;
                  periods_in  = periods_ff + 16'd1;
                  rsp.command = CMD_OFFLOAD;
                  phase_in    = PH_OFFLOAD;
               end else if (deadline_hit(item.now_ms, reply_end_ff)) begin
                  if (!retried_ff) begin
                     retried_in = 1'b1;
                     phase_in   = PH_GO_STANDBY;
                  end else begin
                     retried_in   = 1'b0;
                     rsp.finished = 1'b1;
                     rsp.outcome  = OUT_NO_STANDBY_ACK;
                  end
               end
            end
            PH_OFFLOAD: begin
               if (item.offload_done) begin
                  if (!item.offload_ok) begin
                     rsp.finished = 1'b1;
                     rsp.outcome  = OUT_OFFLOAD_FAILED;
                  end else if (!resume_ff) begin
                     rsp.finished = 1'b1;
                     rsp.outcome  = OUT_DONE;
                  end else begin
                     phase_in = PH_GO_MEASURE;
                  end
               end
            end
            default: begin
               // entry: check settings and load the time owed
               if (cfg.sample_rate_s == 16'd0) begin
                  rsp.finished = 1'b1;
                  rsp.outcome  = OUT_BAD_RATE;
               end else if (cfg.profile_time_s == 32'd0) begin
                  rsp.finished = 1'b1;
                  rsp.outcome  = OUT_BAD_DURATION;
               end else if (longest_s > limit_s) begin
                  rsp.finished = 1'b1;
                  rsp.outcome  = OUT_PERIOD_TOO_LONG;
               end else begin
                  remaining_in = cfg.profile_time_s;
                  resume_in    = 1'b0;
                  retried_in   = 1'b0;
                  periods_in   = '0;
                  phase_in     = PH_GO_MEASURE;
               end
            end
         endcase
      end

      rsp.resume_pending = resume_in;
      rsp.period_count   = periods_in;
   end

   // state update once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_ENTRY;
         retried_ff     <= 1'b0;
         remaining_ff   <= '0;
         cur_period_ff  <= '0;
         period_end_ff  <= '0;
         reply_end_ff   <= '0;
         resume_ff      <= 1'b0;
         measure_ack_ff <= 1'b0;
         standby_ack_ff <= 1'b0;
         periods_ff     <= '0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         retried_ff     <= retried_in;
         remaining_ff   <= remaining_in;
         cur_period_ff  <= cur_period_in;
         period_end_ff  <= period_end_in;
         reply_end_ff   <= reply_end_in;
         resume_ff      <= resume_in;
         measure_ack_ff <= measure_ack_in;
         standby_ack_ff <= standby_ack_in;
         periods_ff     <= periods_in;
      end
   end

endmodule

### sv/periodic_measure_offload_sequencer_top.sv
// An item waits in the input register until the result slot frees. Throughput: one
// item per cycle unless the output stalls; the poll step is one pass between the item
// register and the result register, so the sequencer state is ready for the next
// item. A result waiting on a stalled output still lets one further item be taken.
// Reset (synchronous, active high) returns the sequencer to its entry phase,
// empties both registers and restores the configuration defaults.
`include "periodic_measure_offload_sequencer_top_macros.svh"

module periodic_measure_offload_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pmos_pkg::req_item_type         req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pmos_pkg::rsp_item_type         rsp_item,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pmos_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import pmos_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type step_rsp;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_accept;
   logic         advance;

   pmos_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pmos_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (in_item_ff),
      .rsp     (step_rsp)
   );

   // item moves from input register to result register when the result slot frees
   assign advance    = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // finished and a nonzero outcome go together
   `PMOS_CHECK(a_fin_outcome, !rsp_valid_ff || (rsp_item_ff.finished == (rsp_item_ff.outcome != OUT_RUNNING)))
   // a period length only rides with go-measure
   `PMOS_CHECK(a_period_cmd, !rsp_valid_ff || rsp_item_ff.command == CMD_GO_MEASURE || rsp_item_ff.command_period_s == 16'd0)
   // a processed item always lands in the result register
   `PMOS_CHECK_NEXT(a_advance_lands, advance, rsp_valid_ff)
   // a held item is not dropped from the input register
   `PMOS_CHECK_NEXT(a_hold_item, in_valid_ff && !advance, in_valid_ff)

endmodule
